>>> rtl/core/mss_pkg.sv
// shared types, codes and glyph decode for the seven-segment scanner
package mss_pkg;

    // event codes carried in the kind field
    localparam logic [1:0] KIND_SCAN  = 2'd0;
    localparam logic [1:0] KIND_DIM   = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // blink mode codes
    localparam logic [1:0] MODE_STEADY  = 2'd0;
    localparam logic [1:0] MODE_BLINK_S = 2'd1;
    localparam logic [1:0] MODE_BLINK_M = 2'd2;
    localparam logic [1:0] MODE_BLINK_L = 2'd3;

    // blink tick limits, toggle once the count passes them
    localparam logic [9:0] LIMIT_S = 10'd244;
    localparam logic [9:0] LIMIT_M = 10'd488;
    localparam logic [9:0] LIMIT_L = 10'd977;

    localparam logic [6:0] BLANK_SEGS = 7'h7f;
    localparam logic [7:0] BLANK_CHAR = 8'h7f;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] digit_index;
        logic [7:0] write_value;
    } t_in_word;

    typedef struct packed {
        logic [6:0] segments_n;
        logic       point_n;
        logic [3:0] common_select;
    } t_out_word;

    // input register contents handed to the core
    typedef struct packed {
        logic     valid;
        t_in_word word;
    } t_stage;

    // active-high hex font, segment a in bit 0
    function automatic logic [6:0] hex_font(input logic [3:0] code);
        logic [6:0] segs;
        unique case (code)
            4'h0: segs = 7'h3f;
            4'h1: segs = 7'h06;
            4'h2: segs = 7'h5b;
            4'h3: segs = 7'h4f;
            4'h4: segs = 7'h66;
            4'h5: segs = 7'h6d;
            4'h6: segs = 7'h7d;
            4'h7: segs = 7'h07;
            4'h8: segs = 7'h7f;
            4'h9: segs = 7'h6f;
            4'ha: segs = 7'h77;
            4'hb: segs = 7'h7c;
            4'hc: segs = 7'h39;
            4'hd: segs = 7'h5e;
            4'he: segs = 7'h79;
            4'hf: segs = 7'h71;
            default: segs = 7'h00;
        endcase
        return segs;
    endfunction

    // character byte plus digit enable to an output word
    function automatic t_out_word glyph_word(input logic [7:0] ch, input logic [3:0] common);
        t_out_word w;
        if (ch[6:4] == 3'd0) begin
            w.segments_n = ~hex_font(ch[3:0]);
        end else begin
            w.segments_n = BLANK_SEGS;
        end
        w.point_n       = ~ch[7];
        w.common_select = common;
        return w;
    endfunction

    // power-up character for each digit, blank beyond the fourth
    function automatic logic [7:0] boot_char(input int idx);
        logic [7:0] ch;
        unique case (idx)
            0:       ch = 8'h0b;
            1:       ch = 8'h0e;
            2:       ch = 8'h0e;
            3:       ch = 8'h0f;
            default: ch = BLANK_CHAR;
        endcase
        return ch;
    endfunction

endpackage

>>> rtl/core/mss_chan_if.sv
// valid/ready channels for input and result words
interface mss_in_if;
    logic              valid;
    logic              ready;
    mss_pkg::t_in_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

interface mss_out_if;
    logic               valid;
    logic               ready;
    mss_pkg::t_out_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

>>> rtl/core/mss_in_stage.sv
// input register that takes one word per cycle from the input channel unless the held word is stalled
module mss_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mss_in_if.sink            i_in,
    input  logic              i_advance,
    output mss_pkg::t_stage   o_stage
);

    logic              r_valid;
    mss_pkg::t_in_word r_word;
    logic              w_accept;

    // free slot or the held word moves on this cycle
    assign i_in.ready = !r_valid || i_advance;
    assign w_accept   = i_in.valid && i_in.ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word <= i_in.word;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.word  = r_word;

endmodule

>>> rtl/core/mss_core.sv
// display state: character store, scan position, blink timer and result decode
module mss_core #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_wr_data,
    input  logic               i_fire,
    input  mss_pkg::t_in_word  i_word,
    output logic               o_res_valid,
    output mss_pkg::t_out_word o_res_word
);

    localparam int         PW  = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [3:0] DC4 = 4'(DIGIT_COUNT);

    logic [7:0]    r_store [DIGIT_COUNT];
    logic [PW-1:0] r_pos;
    logic [PW-1:0] n_pos;
    logic          r_visible;
    logic          n_visible;
    logic [9:0]    r_ticks;
    logic [9:0]    n_ticks;
    logic [1:0]    r_mode;

    logic [9:0]    w_tick_inc;
    logic [9:0]    w_limit;
    logic          w_scan;
    logic          w_dim;
    logic          w_wr_hit;
    logic [2:0]    w_wr_idx;
    logic [3:0]    w_common;
    logic          w_last;

    assign w_scan = i_fire && (i_word.kind == mss_pkg::KIND_SCAN);
    assign w_dim  = i_fire && (i_word.kind == mss_pkg::KIND_DIM);

    // blink mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= mss_pkg::MODE_STEADY;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    // toggle limit for the current mode
    always_comb begin
        unique case (r_mode)
            mss_pkg::MODE_STEADY:  w_limit = '0;
            mss_pkg::MODE_BLINK_S: w_limit = mss_pkg::LIMIT_S;
            mss_pkg::MODE_BLINK_M: w_limit = mss_pkg::LIMIT_M;
            mss_pkg::MODE_BLINK_L: w_limit = mss_pkg::LIMIT_L;
            default:               w_limit = mss_pkg::LIMIT_L;
        endcase
    end

    assign w_tick_inc = r_ticks + 10'd1;
    assign w_last     = (32'(r_pos) == DIGIT_COUNT - 1);

    // blink timer and scan position on a scan tick
    always_comb begin
        n_ticks   = r_ticks;
        n_visible = r_visible;
        n_pos     = r_pos;
        if (w_scan) begin
            if (r_mode == mss_pkg::MODE_STEADY) begin
                n_visible = 1'b1;
                n_ticks   = '0;
            end else if (w_tick_inc > w_limit) begin
                n_visible = !r_visible;
                n_ticks   = '0;
            end else begin
                n_ticks = w_tick_inc;
            end
            n_pos = w_last ? '0 : r_pos + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks   <= '0;
            r_visible <= 1'b1;
            r_pos     <= '0;
        end else begin
            r_ticks   <= n_ticks;
            r_visible <= n_visible;
            r_pos     <= n_pos;
        end
    end

    // character writes, digits numbered from one
    assign w_wr_idx = i_word.digit_index - 3'd1;
    assign w_wr_hit = i_fire && (i_word.kind == mss_pkg::KIND_WRITE)
                      && (i_word.digit_index != 3'd0)
                      && ({1'b0, i_word.digit_index} <= DC4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                r_store[i] <= mss_pkg::boot_char(i);
            end
        end else if (w_wr_hit) begin
            r_store[w_wr_idx[PW-1:0]] <= i_word.write_value;
        end
    end

    // one-hot enable, digits past the fourth have no line
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            w_common[b] = (32'(r_pos) == b);
        end
    end

    // result word: blank on dim, current digit on a visible scan
    assign o_res_valid = w_dim || (w_scan && n_visible);
    assign o_res_word  = w_dim ? mss_pkg::glyph_word(mss_pkg::BLANK_CHAR, 4'd0)
                               : mss_pkg::glyph_word(r_store[r_pos], w_common);

endmodule

>>> rtl/core/multiplexed_seven_segment_scanner.sv
// Four-digit multiplexed seven-segment scanner. Each word on i_in is a scan tick, a dim event
// or a character write. A scan tick steps the blink timer (mode set through i_cfg_wr_*) and,
// while the display is visible, gives one result word with the active-low segments, point and
// one-hot digit enable of the current digit before the scan moves on; a dim event gives an
// all-off word; writes and hidden ticks give none. One word is taken every cycle unless o_out
// stalls: it is held in the input register, is decoded against the display state when it
// advances, and its result is loaded into the output register, which drives o_out.
// A stall on o_out holds the input register once the output register is full.
module multiplexed_seven_segment_scanner #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_wr_data,
    mss_in_if.sink     i_in,
    mss_out_if.source  o_out
);

    mss_pkg::t_stage    w_stage;
    logic               w_advance;
    logic               w_res_valid;
    mss_pkg::t_out_word w_res_word;
    logic               r_out_valid;
    mss_pkg::t_out_word r_out_word;

    // held word moves when the output register is free or draining
    assign w_advance = w_stage.valid && (!r_out_valid || o_out.ready);

    mss_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (w_advance),
        .o_stage   (w_stage)
    );

    mss_core #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (w_advance),
        .i_word        (w_stage.word),
        .o_res_valid   (w_res_valid),
        .o_res_word    (w_res_word)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out_word <= w_res_word;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.word  = r_out_word;

`ifndef SYNTHESIS
    a_onehot_enable : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> $onehot0(o_out.word.common_select))
        else $error("digit enable not one-hot");

    a_stage_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stage.valid && !w_advance) |=> (w_stage.valid && $stable(w_stage.word)))
        else $error("held input word lost or changed");

    a_dim_blank : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (w_stage.word.kind == mss_pkg::KIND_DIM))
        |=> (o_out.valid && (o_out.word.segments_n == mss_pkg::BLANK_SEGS)
             && o_out.word.point_n && (o_out.word.common_select == 4'd0)))
        else $error("dim event did not give a blank word");

    a_write_silent : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (w_stage.word.kind == mss_pkg::KIND_WRITE)) |-> !w_res_valid)
        else $error("write produced a result");
`endif

endmodule
